/* rtl/vva_pkg.sv */
// ----------------------------------------------------------------------------
// vva_pkg
// Types and constants shared by the vector ALU front end, back end and
// divide/square-root sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package vva_pkg;

	localparam logic [3:0] FN_BCAST = 4'd0;
	localparam logic [3:0] FN_ADD   = 4'd1;
	localparam logic [3:0] FN_SUB   = 4'd2;
	localparam logic [3:0] FN_MUL   = 4'd3;
	localparam logic [3:0] FN_DIV   = 4'd4;
	localparam logic [3:0] FN_ADDS  = 4'd5;
	localparam logic [3:0] FN_SUBS  = 4'd6;
	localparam logic [3:0] FN_MULS  = 4'd7;
	localparam logic [3:0] FN_DIVS  = 4'd8;
	localparam logic [3:0] FN_DOT   = 4'd9;
	localparam logic [3:0] FN_LEN   = 4'd10;
	localparam logic [3:0] FN_NORM  = 4'd11;
	localparam logic [3:0] FN_CROSS = 4'd12;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	localparam logic [2:0] REG_EPSILON = 3'd0;
	localparam logic [16:0] EPSILON_RESET = 17'd1;

	typedef enum logic [3:0] {
		OP_BCAST, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ADDS, OP_SUBS,
		OP_MULS, OP_DIVS, OP_DOT, OP_LEN, OP_NORM, OP_CROSS, OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		SM_DIV, SM_NORM, SM_LEN
	} smode_t;

	typedef enum logic [2:0] {
		SS_IDLE, SS_SQRT, SS_CHK, SS_DIV, SS_DONE
	} seq_state_t;

	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] u;
		logic [2:0][31:0] v;
		logic [31:0]      s;
	} item_t;

	typedef struct packed {
		smode_t           mode;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic [63:0]      sq;
	} seq_req_t;

	typedef struct packed {
		logic [2:0][31:0] r;
		logic [31:0]      rs;
		logic             ov;
		logic             dz;
	} res_t;

endpackage

`default_nettype wire

/* rtl/vva_front.sv */
// ----------------------------------------------------------------------------
// vva_front
// Accepts commands, decodes the function code and queues the items.
// ----------------------------------------------------------------------------
`default_nettype none

module vva_front #(
	parameter int QDEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [3:0]     func,
	input  wire logic [31:0]    u_x,
	input  wire logic [31:0]    u_y,
	input  wire logic [31:0]    u_z,
	input  wire logic [31:0]    v_x,
	input  wire logic [31:0]    v_y,
	input  wire logic [31:0]    v_z,
	input  wire logic [31:0]    scalar_in,
	output logic                busy,
	output vva_pkg::item_t      item,
	output logic                item_valid,
	input  wire logic           pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	vva_pkg::item_t mem_q [QDEPTH];
	vva_pkg::item_t dec;
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push;

	always_comb begin
		dec.u = {u_z, u_y, u_x};
		dec.v = {v_z, v_y, v_x};
		dec.s = scalar_in;
		case (func)
			vva_pkg::FN_BCAST: dec.op = vva_pkg::OP_BCAST;
			vva_pkg::FN_ADD:   dec.op = vva_pkg::OP_ADD;
			vva_pkg::FN_SUB:   dec.op = vva_pkg::OP_SUB;
			vva_pkg::FN_MUL:   dec.op = vva_pkg::OP_MUL;
			vva_pkg::FN_DIV:   dec.op = vva_pkg::OP_DIV;
			vva_pkg::FN_ADDS:  dec.op = vva_pkg::OP_ADDS;
			vva_pkg::FN_SUBS:  dec.op = vva_pkg::OP_SUBS;
			vva_pkg::FN_MULS:  dec.op = vva_pkg::OP_MULS;
			vva_pkg::FN_DIVS:  dec.op = vva_pkg::OP_DIVS;
			vva_pkg::FN_DOT:   dec.op = vva_pkg::OP_DOT;
			vva_pkg::FN_LEN:   dec.op = vva_pkg::OP_LEN;
			vva_pkg::FN_NORM:  dec.op = vva_pkg::OP_NORM;
			vva_pkg::FN_CROSS: dec.op = vva_pkg::OP_CROSS;
			default:           dec.op = vva_pkg::OP_NONE;
		endcase
	end

	assign busy       = (cnt_q == CW'(QDEPTH));
	assign push       = start && !busy;
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/vva_seq.sv */
// ----------------------------------------------------------------------------
// vva_seq
// Shared iterative unit: restoring division on three lanes and a
// two-bits-per-cycle integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module vva_seq #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  vva_pkg::seq_req_t      req,
	input  wire logic [16:0]       epsilon,
	output logic                   busy,
	output vva_pkg::res_t          res,
	output logic                   res_valid
);

	localparam int DW   = 32 + FRAC_BITS;
	localparam int CNTW = $clog2(DW + 1);

	vva_pkg::seq_state_t state_q, state_d;
	vva_pkg::smode_t     mode_q;
	logic [CNTW-1:0]     cnt_q;
	logic [2:0][31:0]    a_q;
	logic [2:0][DW-1:0]  dvd_q;
	logic [2:0][DW-1:0]  quo_q;
	logic [2:0][31:0]    rem_q;
	logic [2:0][31:0]    dsr_q;
	logic [2:0]          neg_q;
	logic [2:0]          zero_q;
	logic [63:0]         sqn_q;
	logic [33:0]         sqrem_q;
	logic [31:0]         root_q;
	logic                small_q;
	logic [35:0]         rem2, trial;
	logic                big_enough;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	assign rem2       = {sqrem_q, sqn_q[63:62]};
	assign trial      = {2'b00, root_q, 2'b01};
	assign big_enough = (root_q > {15'd0, epsilon});

	always_comb begin
		state_d = state_q;
		case (state_q)
			vva_pkg::SS_IDLE: begin
				if (load) begin
					state_d = (req.mode == vva_pkg::SM_DIV) ? vva_pkg::SS_DIV
						: vva_pkg::SS_SQRT;
				end
			end
			vva_pkg::SS_SQRT: begin
				if (cnt_q == CNTW'(1)) begin
					state_d = vva_pkg::SS_CHK;
				end
			end
			vva_pkg::SS_CHK: begin
				state_d = (mode_q == vva_pkg::SM_NORM && big_enough) ? vva_pkg::SS_DIV
					: vva_pkg::SS_DONE;
			end
			vva_pkg::SS_DIV: begin
				if (cnt_q == CNTW'(1)) begin
					state_d = vva_pkg::SS_DONE;
				end
			end
			vva_pkg::SS_DONE: state_d = vva_pkg::SS_IDLE;
			default: state_d = vva_pkg::SS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vva_pkg::SS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vva_pkg::SS_IDLE: begin
				if (load) begin
					mode_q  <= req.mode;
					a_q     <= req.a;
					sqn_q   <= req.sq;
					sqrem_q <= '0;
					root_q  <= '0;
					small_q <= 1'b0;
					cnt_q   <= (req.mode == vva_pkg::SM_DIV) ? CNTW'(DW) : CNTW'(32);
					for (int i = 0; i < 3; i++) begin
						dvd_q[i]  <= {mag32(req.a[i]), {FRAC_BITS{1'b0}}};
						dsr_q[i]  <= mag32(req.b[i]);
						neg_q[i]  <= req.a[i][31] ^ req.b[i][31];
						zero_q[i] <= (req.b[i] == '0);
						rem_q[i]  <= '0;
						quo_q[i]  <= '0;
					end
				end
			end
			vva_pkg::SS_SQRT: begin
				cnt_q <= cnt_q - 1'b1;
				sqn_q <= {sqn_q[61:0], 2'b00};
				if (rem2 >= trial) begin
					sqrem_q <= 34'(rem2 - trial);
					root_q  <= {root_q[30:0], 1'b1};
				end else begin
					sqrem_q <= rem2[33:0];
					root_q  <= {root_q[30:0], 1'b0};
				end
			end
			vva_pkg::SS_CHK: begin
				small_q <= !big_enough;
				cnt_q   <= CNTW'(DW);
				for (int i = 0; i < 3; i++) begin
					dvd_q[i]  <= {mag32(a_q[i]), {FRAC_BITS{1'b0}}};
					dsr_q[i]  <= root_q;
					neg_q[i]  <= a_q[i][31];
					zero_q[i] <= 1'b0;
					rem_q[i]  <= '0;
					quo_q[i]  <= '0;
				end
			end
			vva_pkg::SS_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				for (int i = 0; i < 3; i++) begin
					if ({rem_q[i], dvd_q[i][DW-1]} >= {1'b0, dsr_q[i]}) begin
						rem_q[i] <= 32'({rem_q[i], dvd_q[i][DW-1]} - {1'b0, dsr_q[i]});
						quo_q[i] <= {quo_q[i][DW-2:0], 1'b1};
					end else begin
						rem_q[i] <= {rem_q[i][30:0], dvd_q[i][DW-1]};
						quo_q[i] <= {quo_q[i][DW-2:0], 1'b0};
					end
					dvd_q[i] <= {dvd_q[i][DW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != vva_pkg::SS_IDLE);
		res_valid = (state_q == vva_pkg::SS_DONE);
		res       = '0;
		case (mode_q)
			vva_pkg::SM_LEN: begin
				if (root_q[31]) begin
					res.rs = vva_pkg::S32_MAX;
					res.ov = 1'b1;
				end else begin
					res.rs = root_q;
				end
			end
			vva_pkg::SM_DIV, vva_pkg::SM_NORM: begin
				if (!(mode_q == vva_pkg::SM_NORM && small_q)) begin
					for (int i = 0; i < 3; i++) begin
						if (zero_q[i]) begin
							res.r[i] = a_q[i][31] ? vva_pkg::S32_MIN : vva_pkg::S32_MAX;
							res.dz   = 1'b1;
						end else if (!neg_q[i]) begin
							if (quo_q[i] > DW'(vva_pkg::S32_MAX)) begin
								res.r[i] = vva_pkg::S32_MAX;
								res.ov   = 1'b1;
							end else begin
								res.r[i] = quo_q[i][31:0];
							end
						end else begin
							if (quo_q[i] > DW'(vva_pkg::S32_MIN)) begin
								res.r[i] = vva_pkg::S32_MIN;
								res.ov   = 1'b1;
							end else begin
								res.r[i] = ~quo_q[i][31:0] + 32'd1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/vva_back.sv */
// ----------------------------------------------------------------------------
// vva_back
// Execution back end: operand stage, six-lane multiplier stage, combine
// stage and result register, with the shared divide/square-root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module vva_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  vva_pkg::item_t     item,
	input  wire logic          item_valid,
	output logic               pop,
	input  wire logic [16:0]   epsilon,
	output vva_pkg::res_t      res,
	output logic               res_valid
);

	localparam logic signed [65:0] LIM_HI = 66'sd2147483647;
	localparam logic signed [65:0] LIM_LO = -66'sd2147483648;

	logic                     valid_s1, valid_s2, res_valid_q;
	vva_pkg::item_t           itm_s1, itm_s2;
	logic signed [5:0][63:0]  prod_s2;
	logic signed [2:0][32:0]  addv_s2;
	logic signed [5:0][63:0]  prod;
	logic signed [2:0][32:0]  addv;
	logic                     mv1, adv2, is_long;
	vva_pkg::res_t            comb_res, res_q, seq_res;
	vva_pkg::seq_req_t        sreq;
	logic                     seq_busy, seq_valid;

	function automatic logic [32:0] sat66(input logic signed [65:0] x);
		if (x > LIM_HI) begin
			return {1'b1, vva_pkg::S32_MAX};
		end else if (x < LIM_LO) begin
			return {1'b1, vva_pkg::S32_MIN};
		end
		return {1'b0, x[31:0]};
	endfunction

	always_comb begin
		logic [2:0][31:0] ma, mb, mc, md;
		for (int i = 0; i < 3; i++) begin
			ma[i] = itm_s1.u[i];
			mb[i] = itm_s1.v[i];
			mc[i] = itm_s1.v[(i + 1) % 3];
			md[i] = itm_s1.u[(i + 2) % 3];
		end
		case (itm_s1.op)
			vva_pkg::OP_MULS: begin
				mb = {3{itm_s1.s}};
			end
			vva_pkg::OP_LEN, vva_pkg::OP_NORM: begin
				mb = itm_s1.u;
			end
			vva_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = itm_s1.u[(i + 1) % 3];
					mb[i] = itm_s1.v[(i + 2) % 3];
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			prod[i]     = $signed(ma[i]) * $signed(mb[i]);
			prod[i + 3] = $signed(mc[i]) * $signed(md[i]);
		end
		for (int i = 0; i < 3; i++) begin
			case (itm_s1.op)
				vva_pkg::OP_SUB:  addv[i] = $signed({itm_s1.u[i][31], itm_s1.u[i]})
					- $signed({itm_s1.v[i][31], itm_s1.v[i]});
				vva_pkg::OP_ADDS: addv[i] = $signed({itm_s1.u[i][31], itm_s1.u[i]})
					+ $signed({itm_s1.s[31], itm_s1.s});
				vva_pkg::OP_SUBS: addv[i] = $signed({itm_s1.u[i][31], itm_s1.u[i]})
					- $signed({itm_s1.s[31], itm_s1.s});
				default:          addv[i] = $signed({itm_s1.u[i][31], itm_s1.u[i]})
					+ $signed({itm_s1.v[i][31], itm_s1.v[i]});
			endcase
		end
	end

	always_comb begin
		logic signed [65:0] t;
		logic [32:0] sv;
		comb_res = '0;
		t  = '0;
		sv = '0;
		case (itm_s2.op)
			vva_pkg::OP_BCAST: begin
				comb_res.r = {3{itm_s2.s}};
			end
			vva_pkg::OP_ADD, vva_pkg::OP_SUB, vva_pkg::OP_ADDS, vva_pkg::OP_SUBS: begin
				for (int i = 0; i < 3; i++) begin
					sv = sat66(66'($signed(addv_s2[i])));
					comb_res.r[i] = sv[31:0];
					comb_res.ov   = comb_res.ov | sv[32];
				end
			end
			vva_pkg::OP_MUL, vva_pkg::OP_MULS: begin
				for (int i = 0; i < 3; i++) begin
					t  = 66'($signed(prod_s2[i])) >>> FRAC_BITS;
					sv = sat66(t);
					comb_res.r[i] = sv[31:0];
					comb_res.ov   = comb_res.ov | sv[32];
				end
			end
			vva_pkg::OP_DOT: begin
				t  = (66'($signed(prod_s2[0])) + 66'($signed(prod_s2[1]))
					+ 66'($signed(prod_s2[2]))) >>> FRAC_BITS;
				sv = sat66(t);
				comb_res.rs = sv[31:0];
				comb_res.ov = sv[32];
			end
			vva_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					t  = (66'($signed(prod_s2[i])) - 66'($signed(prod_s2[i + 3])))
						>>> FRAC_BITS;
					sv = sat66(t);
					comb_res.r[i] = sv[31:0];
					comb_res.ov   = comb_res.ov | sv[32];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sreq.a  = itm_s2.u;
		sreq.b  = itm_s2.v;
		sreq.sq = 64'(prod_s2[0]) + 64'(prod_s2[1]) + 64'(prod_s2[2]);
		is_long = 1'b1;
		case (itm_s2.op)
			vva_pkg::OP_DIV:  sreq.mode = vva_pkg::SM_DIV;
			vva_pkg::OP_DIVS: begin
				sreq.mode = vva_pkg::SM_DIV;
				sreq.b    = {3{itm_s2.s}};
			end
			vva_pkg::OP_LEN:  sreq.mode = vva_pkg::SM_LEN;
			vva_pkg::OP_NORM: sreq.mode = vva_pkg::SM_NORM;
			default: begin
				sreq.mode = vva_pkg::SM_DIV;
				is_long   = 1'b0;
			end
		endcase
	end

	assign adv2 = valid_s2 && !seq_busy;
	assign mv1  = valid_s1 && (!valid_s2 || adv2);
	assign pop  = item_valid && (!valid_s1 || mv1);

	vva_seq #(
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv2 && is_long),
		.req       (sreq),
		.epsilon   (epsilon),
		.busy      (seq_busy),
		.res       (seq_res),
		.res_valid (seq_valid)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			itm_s1 <= item;
		end
		if (mv1) begin
			itm_s2  <= itm_s1;
			prod_s2 <= prod;
			addv_s2 <= addv;
		end
		if (seq_valid) begin
			res_q <= seq_res;
		end else if (adv2 && !is_long) begin
			res_q <= comb_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (mv1) begin
				valid_s1 <= 1'b0;
			end
			if (mv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			res_valid_q <= seq_valid || (adv2 && !is_long);
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

/* rtl/vec3_vector_alu_core.sv */
// ----------------------------------------------------------------------------
// vec3_vector_alu_core
// Three-component vector ALU in signed fixed point with FRAC_BITS fraction
// bits. Broadcast, add, subtract, multiply, dot and cross products issue
// one item per cycle while the iterative unit is idle and return through the
// queue, operand stage, multiplier stage and result register; the result is
// shown for one cycle on done and the receiver cannot stall it. Divide,
// scalar divide, length and normalize run in one shared iterative unit
// and hold the back end: length takes a square root, normalize divides by
// the root when it exceeds epsilon. Up to QDEPTH items queue in front of
// the back end; busy is high while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_vector_alu_core #(
	parameter int FRAC_BITS = 16,
	parameter int QDEPTH    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  func,
	input  wire logic [31:0] u_x,
	input  wire logic [31:0] u_y,
	input  wire logic [31:0] u_z,
	input  wire logic [31:0] v_x,
	input  wire logic [31:0] v_y,
	input  wire logic [31:0] v_z,
	input  wire logic [31:0] scalar_in,
	output logic             done,
	output logic [31:0]      res_x,
	output logic [31:0]      res_y,
	output logic [31:0]      res_z,
	output logic [31:0]      res_scalar,
	output logic             overflow,
	output logic             div_zero
);

	logic [16:0]    epsilon_q;
	vva_pkg::item_t item;
	logic           item_valid, pop;
	vva_pkg::res_t  res;

	assign pready = 1'b1;
	assign prdata = ({paddr[2], 2'b00} == vva_pkg::REG_EPSILON) ? {15'd0, epsilon_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= vva_pkg::EPSILON_RESET;
		end else if (psel && penable && pwrite
				&& {paddr[2], 2'b00} == vva_pkg::REG_EPSILON) begin
			epsilon_q <= pwdata[16:0];
		end
	end

	vva_front #(
		.QDEPTH (QDEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.u_x        (u_x),
		.u_y        (u_y),
		.u_z        (u_z),
		.v_x        (v_x),
		.v_y        (v_y),
		.v_z        (v_z),
		.scalar_in  (scalar_in),
		.busy       (busy),
		.item       (item),
		.item_valid (item_valid),
		.pop        (pop)
	);

	vva_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.pop        (pop),
		.epsilon    (epsilon_q),
		.res        (res),
		.res_valid  (done)
	);

	assign res_x      = res.r[0];
	assign res_y      = res.r[1];
	assign res_z      = res.r[2];
	assign res_scalar = res.rs;
	assign overflow   = res.ov;
	assign div_zero   = res.dz;

	a_vec_no_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res_x != '0 || res_y != '0 || res_z != '0) |-> res_scalar == '0)
		else $error("vector result carries a nonzero scalar");

	a_dz_vector_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_zero |-> res_scalar == '0)
		else $error("divide-by-zero flag on a scalar result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("queue filled without an accepted command");

endmodule

`default_nettype wire

/* bench/vva_checker.sv */
// ----------------------------------------------------------------------------
// vva_checker
// Watches the command and result beats of the vector ALU, computes the
// expected vector, scalar and flags for every accepted command, and
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module vva_checker #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [3:0]  func,
	input  wire logic [31:0] u_x,
	input  wire logic [31:0] u_y,
	input  wire logic [31:0] u_z,
	input  wire logic [31:0] v_x,
	input  wire logic [31:0] v_y,
	input  wire logic [31:0] v_z,
	input  wire logic [31:0] scalar_in,
	input  wire logic        done,
	input  wire logic [31:0] res_x,
	input  wire logic [31:0] res_y,
	input  wire logic [31:0] res_z,
	input  wire logic [31:0] res_scalar,
	input  wire logic        overflow,
	input  wire logic        div_zero,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] x, y, z, s;
		logic        ov, dz;
	} vres_t;

	vres_t       expected_q[$];
	logic [16:0] eps_shadow;

	function automatic longint sat(longint val, ref logic ov);
		if (val > 64'sd2147483647) begin
			ov = 1'b1;
			return 64'sd2147483647;
		end
		if (val < -64'sd2147483648) begin
			ov = 1'b1;
			return -64'sd2147483648;
		end
		return val;
	endfunction

	// Floor division by 2^FRAC_BITS of a 128-bit value, clamped to +/-(2^63 - 1).
	function automatic longint fx_floor(logic signed [127:0] p);
		logic signed [127:0] q;
		q = p >>> FRAC_BITS;
		if (q > 128'sd9223372036854775807)
			return 64'sd9223372036854775807;
		if (q < -128'sd9223372036854775807)
			return -64'sd9223372036854775807;
		return longint'(q);
	endfunction

	function automatic longint fx_quot(longint a, longint b, ref logic ov, ref logic dz);
		if (b == 0) begin
			dz = 1'b1;
			return (a < 0) ? -64'sd2147483648 : 64'sd2147483647;
		end
		return sat((a <<< FRAC_BITS) / b, ov);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] rt, bt;
		rt = '0;
		bt = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= rt + bt) begin
				n = n - (rt + bt);
				rt = (rt >> 1) + bt;
			end else begin
				rt = rt >> 1;
			end
			bt = bt >> 2;
		end
		return rt;
	endfunction

	function automatic vres_t compute_vector_op(logic [3:0] fn, logic [31:0] a[3],
		logic [31:0] b[3], logic [31:0] sc);
		vres_t       e;
		longint      u[3], v[3], s, r[3], rs, ln;
		logic        ov, dz;
		logic signed [127:0] p;
		logic [63:0] sq;
		ov = 1'b0;
		dz = 1'b0;
		rs = 0;
		s = longint'($signed(sc));
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'($signed(a[i]));
			v[i] = longint'($signed(b[i]));
			r[i] = 0;
		end
		case (fn)
			vva_pkg::FN_BCAST: for (int i = 0; i < 3; i++) r[i] = s;
			vva_pkg::FN_ADD:   for (int i = 0; i < 3; i++) r[i] = sat(u[i] + v[i], ov);
			vva_pkg::FN_SUB:   for (int i = 0; i < 3; i++) r[i] = sat(u[i] - v[i], ov);
			vva_pkg::FN_MUL:
				for (int i = 0; i < 3; i++) r[i] = sat(fx_floor(u[i] * v[i]), ov);
			vva_pkg::FN_DIV:
				for (int i = 0; i < 3; i++) r[i] = fx_quot(u[i], v[i], ov, dz);
			vva_pkg::FN_ADDS:  for (int i = 0; i < 3; i++) r[i] = sat(u[i] + s, ov);
			vva_pkg::FN_SUBS:  for (int i = 0; i < 3; i++) r[i] = sat(u[i] - s, ov);
			vva_pkg::FN_MULS:
				for (int i = 0; i < 3; i++) r[i] = sat(fx_floor(u[i] * s), ov);
			vva_pkg::FN_DIVS:
				for (int i = 0; i < 3; i++) r[i] = fx_quot(u[i], s, ov, dz);
			vva_pkg::FN_DOT: begin
				p = 128'(u[0] * v[0]) + 128'(u[1] * v[1]) + 128'(u[2] * v[2]);
				rs = sat(fx_floor(p), ov);
			end
			vva_pkg::FN_LEN, vva_pkg::FN_NORM: begin
				sq = 64'(u[0] * u[0]) + 64'(u[1] * u[1]) + 64'(u[2] * u[2]);
				ln = longint'(int_sqrt(sq));
				if (fn == vva_pkg::FN_LEN)
					rs = sat(ln, ov);
				else if (ln > longint'(eps_shadow))
					for (int i = 0; i < 3; i++) r[i] = sat((u[i] <<< FRAC_BITS) / ln, ov);
			end
			vva_pkg::FN_CROSS: begin
				r[0] = sat(fx_floor(128'(u[1] * v[2]) - 128'(v[1] * u[2])), ov);
				r[1] = sat(fx_floor(128'(u[2] * v[0]) - 128'(v[2] * u[0])), ov);
				r[2] = sat(fx_floor(128'(u[0] * v[1]) - 128'(v[0] * u[1])), ov);
			end
			default: ;
		endcase
		e.x = r[0][31:0];
		e.y = r[1][31:0];
		e.z = r[2][31:0];
		e.s = rs[31:0];
		e.ov = ov;
		e.dz = dz;
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		vres_t e;
		if (!arst_n) begin
			eps_shadow <= vva_pkg::EPSILON_RESET;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == vva_pkg::REG_EPSILON)
				eps_shadow <= pwdata[16:0];
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result beat", res_x, 32'd0);
				end else begin
					e = expected_q.pop_front();
					if (res_x !== e.x) report_mismatch("res_x", res_x, e.x);
					if (res_y !== e.y) report_mismatch("res_y", res_y, e.y);
					if (res_z !== e.z) report_mismatch("res_z", res_z, e.z);
					if (res_scalar !== e.s) report_mismatch("res_scalar", res_scalar, e.s);
					if (overflow !== e.ov)
						report_mismatch("overflow", {31'd0, overflow}, {31'd0, e.ov});
					if (div_zero !== e.dz)
						report_mismatch("div_zero", {31'd0, div_zero}, {31'd0, e.dz});
				end
			end
			if (start && !busy)
				expected_q.push_back(compute_vector_op(func, '{u_x, u_y, u_z},
					'{v_x, v_y, v_z}, scalar_in));
		end
	end

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the vector ALU with directed corner commands and random command
// beats over several idling phases and epsilon settings, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  func = '0;
	logic [31:0] u_x = '0, u_y = '0, u_z = '0, v_x = '0, v_y = '0, v_z = '0;
	logic [31:0] scalar_in = '0;
	logic        done;
	logic [31:0] res_x, res_y, res_z, res_scalar;
	logic        overflow, div_zero;
	int          fail_count, pending;
	int          idle_cycles = 0;
	int          gap_pct = 0;

	always #5 clk = ~clk;

	vec3_vector_alu_core u_top (.*);

	vva_checker u_chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_epsilon(logic [16:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = vva_pkg::REG_EPSILON;
		pwdata = {15'd0, val};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
			4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom();
		endcase
	endfunction

	// Holds start for one command beat and waits until it is taken.
	task automatic send_command(logic [3:0] fn, logic [31:0] a0, logic [31:0] a1,
		logic [31:0] a2, logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
		logic [31:0] sc);
		while (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = fn;
		{u_x, u_y, u_z} = {a0, a1, a2};
		{v_x, v_y, v_z} = {b0, b1, b2};
		scalar_in = sc;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_random(int count);
		logic [3:0]  fn;
		logic [31:0] s;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			s = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_value();
			send_command(fn, pick_value(), pick_value(), pick_value(),
				($urandom_range(0, 7) == 0) ? 32'd0 : pick_value(), pick_value(),
				pick_value(), s);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int f = 0; f <= 15; f++)
			send_command(4'(f), 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
				32'h7fff_ffff, 32'h0000_0000, 32'hffff_0000, 32'h0002_0000);
		send_command(vva_pkg::FN_DIV, 32'h8000_0000, 32'd0, 32'h0003_0000,
			32'd0, 32'd0, 32'hffff_ffff, 32'd0);
		send_command(vva_pkg::FN_DIVS, 32'hffff_ffff, 32'd0, 32'h8000_0000,
			32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_NORM, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_NORM, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_NORM, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_MUL, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
		send_command(vva_pkg::FN_CROSS, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
		drain_results();

		write_epsilon(17'd0);
		send_command(vva_pkg::FN_NORM, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_random(200);
		drain_results();

		write_epsilon(17'h1_0000);
		gap_pct = 56;
		send_command(vva_pkg::FN_NORM, 32'h0001_0000, 32'd0, 32'd0,
			32'd0, 32'd0, 32'd0, 32'd0);
		send_command(vva_pkg::FN_NORM, 32'h0001_0001, 32'd0, 32'd0,
			32'd0, 32'd0, 32'd0, 32'd0);
		send_random(250);
		drain_results();

		write_epsilon(17'($urandom_range(0, 65536)));
		gap_pct = 26;
		send_random(250);
		drain_results();

		write_epsilon(17'h1_ffff);
		gap_pct = 0;
		send_random(200);
		drain_results();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
